### src/mlfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory LCD frame serializer package
// Sequencer states, command codes and command-byte bits.
// ----------------------------------------------------------------------------
package mlfs_pkg;

  localparam logic [2:0] CMD_PIXEL  = 3'd0;
  localparam logic [2:0] CMD_FILL   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_LINE   = 3'd3;
  localparam logic [2:0] CMD_FBEGIN = 3'd4;
  localparam logic [2:0] CMD_FLINE  = 3'd5;
  localparam logic [2:0] CMD_FEND   = 3'd6;

  localparam logic [7:0] BIT_WRITE_LINE = 8'h01;
  localparam logic [7:0] BIT_VCOM       = 8'h02;
  localparam logic [7:0] BIT_CLEAR      = 8'h04;
  localparam logic [7:0] BYTE_ONES      = 8'hFF;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_FILL   = 10'b00_0000_0010,
    ST_PIX_RD = 10'b00_0000_0100,
    ST_PIX_WR = 10'b00_0000_1000,
    ST_HEAD   = 10'b00_0001_0000,
    ST_CLR    = 10'b00_0010_0000,
    ST_ADDR   = 10'b00_0100_0000,
    ST_DATA   = 10'b00_1000_0000,
    ST_TRAIL  = 10'b01_0000_0000,
    ST_END    = 10'b10_0000_0000
  } state_t;

endpackage

### src/memory_lcd_frame_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory LCD frame serializer
// One-bit-per-pixel frame store and VCOM bit; turns commands into the SPI
// byte stream of a memory LCD, one byte per cycle from the store read port.
// ----------------------------------------------------------------------------
// First byte registered from the state entered on accept; then one byte a cycle.
// Busy: high while a command runs; a pixel write is a read-modify-write on the
//   single store port, and the fill writes one byte a cycle.
// Reset: runs the fill pass with busy high, VCOM set to 1.
// Results are strobed for one cycle each; the receiver cannot stall them.
module memory_lcd_frame_serializer_top #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [6:0] in_pixel_x,
  input  logic [6:0] in_pixel_y,
  input  logic       in_color,
  input  logic [6:0] in_row,
  output logic       out_valid,
  output logic [7:0] out_spi_byte,
  output logic       out_last
);
  import mlfs_pkg::*;

  localparam int ROW_BYTES   = WIDTH / 8;
  localparam int STORE_BYTES = ROW_BYTES * HEIGHT;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [CW-1:0] LAST_CNT  = CW'(ROW_BYTES - 1);
  localparam logic [7:0]    HEIGHT_B  = 8'(HEIGHT);
  localparam logic [9:0]    XLIM      = 10'(ROW_BYTES * 8);

  logic [7:0] store [STORE_BYTES];

  state_t        state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [6:0]    row_r, row_nxt;
  logic [2:0]    xbit_r, xbit_nxt;
  logic          color_r, color_nxt;
  logic          mode_line_r, mode_line_nxt;
  logic          vcom_r, vcom_nxt;
  logic [7:0]    rd_data_r;
  logic          out_valid_nxt;
  logic [7:0]    out_byte_nxt;
  logic          out_last_nxt;
  logic          mem_we;
  logic [7:0]    mem_wd;
  logic [7:0]    pix_mask;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] row_base;
  logic          pix_ok;
  logic          row_ok;
  logic [7:0]    cmd_head;

  assign busy     = (state_r != ST_IDLE);
  assign pix_mask = 8'b1 << xbit_r;
  assign pix_addr = AW'(32'(in_pixel_y) * 32'(ROW_BYTES)) + AW'(in_pixel_x[6:3]);
  assign row_base = AW'(32'(in_row) * 32'(ROW_BYTES));
  assign pix_ok   = ({1'b0, in_pixel_y} < HEIGHT_B) && ({3'b0, in_pixel_x} < XLIM);
  assign row_ok   = ({1'b0, in_row} < HEIGHT_B);
  assign cmd_head = vcom_r ? BIT_VCOM : BYTE_ZERO;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    xbit_nxt      = xbit_r;
    color_nxt     = color_r;
    mode_line_nxt = mode_line_r;
    vcom_nxt      = vcom_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = BYTE_ZERO;
    out_last_nxt  = 1'b0;
    mem_we        = 1'b0;
    mem_wd        = BYTE_ONES;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          row_nxt   = in_row;
          xbit_nxt  = in_pixel_x[2:0];
          color_nxt = in_color;
          unique case (in_cmd)
            CMD_PIXEL: begin
              if (pix_ok) begin
                ptr_nxt   = pix_addr;
                state_nxt = ST_PIX_RD;
              end
            end
            CMD_FILL: begin
              ptr_nxt   = '0;
              state_nxt = ST_FILL;
            end
            CMD_CLEAR: state_nxt = ST_CLR;
            CMD_LINE: begin
              if (row_ok) begin
                ptr_nxt       = row_base;
                mode_line_nxt = 1'b1;
                state_nxt     = ST_HEAD;
              end
            end
            CMD_FBEGIN: begin
              mode_line_nxt = 1'b0;
              state_nxt     = ST_HEAD;
            end
            CMD_FLINE: begin
              if (row_ok) begin
                ptr_nxt       = row_base;
                mode_line_nxt = 1'b0;
                state_nxt     = ST_ADDR;
              end
            end
            CMD_FEND: state_nxt = ST_END;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        mem_we  = 1'b1;
        mem_wd  = BYTE_ONES;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PIX_RD: state_nxt = ST_PIX_WR;
      ST_PIX_WR: begin
        mem_we    = 1'b1;
        mem_wd    = color_r ? (rd_data_r | pix_mask) : (rd_data_r & ~pix_mask);
        state_nxt = ST_IDLE;
      end
      ST_HEAD: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = cmd_head | BIT_WRITE_LINE;
        state_nxt     = mode_line_r ? ST_ADDR : ST_IDLE;
      end
      ST_CLR: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = cmd_head | BIT_CLEAR;
        state_nxt     = ST_END;
      end
      ST_ADDR: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = {1'b0, row_r} + 8'd1;
        ptr_nxt       = ptr_r + 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_DATA;
      end
      ST_DATA: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = rd_data_r;
        ptr_nxt       = ptr_r + 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_TRAIL;
        end
      end
      ST_TRAIL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = mode_line_r ? ST_END : ST_IDLE;
      end
      ST_END: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        vcom_nxt      = ~vcom_r;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[ptr_r] <= mem_wd;
    end
    rd_data_r <= store[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      ptr_r       <= '0;
      vcom_r      <= 1'b1;
      out_valid   <= 1'b0;
      mode_line_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      vcom_r      <= vcom_nxt;
      out_valid   <= out_valid_nxt;
      mode_line_r <= mode_line_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    xbit_r       <= xbit_nxt;
    color_r      <= color_nxt;
    out_spi_byte <= out_byte_nxt;
    out_last     <= out_last_nxt;
  end

endmodule

### tb/sv/lcd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory LCD byte stream checker
// Watches the command and byte channels of the serializer. Keeps its own
// pixel store and VCOM bit, predicts the SPI bytes of every accepted item
// and compares each strobed byte and its last flag against the oldest one.
// ----------------------------------------------------------------------------
module lcd_stream_checker #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [6:0] in_pixel_x,
  input  logic [6:0] in_pixel_y,
  input  logic       in_color,
  input  logic [6:0] in_row,
  input  logic       out_valid,
  input  logic [7:0] out_spi_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         pending,
  output int         bytes_checked
);
  import mlfs_pkg::*;

  localparam int ROW_BYTES   = WIDTH / 8;
  localparam int STORE_BYTES = ROW_BYTES * HEIGHT;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last;
  } lcd_byte_t;

  logic [7:0] frame_store [STORE_BYTES];
  logic       vcom;
  lcd_byte_t  spi_stream_q [$];
  lcd_byte_t  want;

  initial begin
    fail_count    = 0;
    bytes_checked = 0;
    pending       = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t ns: %s: got 0x%02h, want 0x%02h", $time, what, got, exp_val);
    fail_count++;
  endtask

  task automatic fill_store();
    foreach (frame_store[i]) frame_store[i] = BYTE_ONES;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic l);
    spi_stream_q.push_back({b, l});
  endtask

  task automatic push_line(input int r);
    push_byte(8'(r + 1), 1'b0);
    for (int i = 0; i < ROW_BYTES; i++) push_byte(frame_store[r * ROW_BYTES + i], 1'b0);
    push_byte(BYTE_ZERO, 1'b0);
  endtask

  task automatic serialize_command(input logic [2:0] cmd, input int x, input int y,
                                   input logic color, input int r);
    int idx;
    logic [7:0] mask;
    case (cmd)
      CMD_PIXEL: begin
        if (y < HEIGHT && x < ROW_BYTES * 8) begin
          idx  = y * ROW_BYTES + x / 8;
          mask = 8'h01 << (x % 8);
          if (color) frame_store[idx] = frame_store[idx] | mask;
          else frame_store[idx] = frame_store[idx] & ~mask;
        end
      end
      CMD_FILL: fill_store();
      CMD_CLEAR: begin
        push_byte((vcom ? BIT_VCOM : BYTE_ZERO) | BIT_CLEAR, 1'b0);
        push_byte(BYTE_ZERO, 1'b1);
        vcom = ~vcom;
      end
      CMD_LINE: begin
        if (r < HEIGHT) begin
          push_byte((vcom ? BIT_VCOM : BYTE_ZERO) | BIT_WRITE_LINE, 1'b0);
          push_line(r);
          push_byte(BYTE_ZERO, 1'b1);
          vcom = ~vcom;
        end
      end
      CMD_FBEGIN: push_byte((vcom ? BIT_VCOM : BYTE_ZERO) | BIT_WRITE_LINE, 1'b0);
      CMD_FLINE: begin
        if (r < HEIGHT) push_line(r);
      end
      CMD_FEND: begin
        push_byte(BYTE_ZERO, 1'b1);
        vcom = ~vcom;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_store();
      vcom = 1'b1;
      spi_stream_q.delete();
    end else begin
      if (out_valid) begin
        if (spi_stream_q.size() == 0) begin
          report_mismatch("byte with none expected", out_spi_byte, 0);
        end else begin
          want = spi_stream_q.pop_front();
          bytes_checked++;
          if (out_spi_byte !== want.spi_byte)
            report_mismatch("spi_byte", out_spi_byte, want.spi_byte);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      if (start && !busy)
        serialize_command(in_cmd, in_pixel_x, in_pixel_y, in_color, in_row);
    end
    pending <= spi_stream_q.size();
  end

endmodule

### tb/sv/tb_memory_lcd_frame_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory LCD frame serializer testbench
// Drives directed corner commands, then random pixel writes, line refreshes,
// framed line sequences, clears, fills and stray commands with random gaps. A side
// checker predicts and compares the byte stream; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_memory_lcd_frame_serializer_top;
  import mlfs_pkg::*;

  localparam int WIDTH  = 128;
  localparam int HEIGHT = 128;
  localparam logic [2:0] CMD_SPARE = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_cmd;
  logic [6:0] in_pixel_x;
  logic [6:0] in_pixel_y;
  logic       in_color;
  logic [6:0] in_row;
  logic       out_valid;
  logic [7:0] out_spi_byte;
  logic       out_last;

  int fail_count;
  int pending;
  int bytes_checked;
  int n_sent;
  int n_refresh;
  int n_pixel;
  int n_fill;
  int drained_once;
  bit quiet;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  memory_lcd_frame_serializer_top #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .in_color    (in_color),
    .in_row      (in_row),
    .out_valid   (out_valid),
    .out_spi_byte(out_spi_byte),
    .out_last    (out_last)
  );

  lcd_stream_checker #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_color     (in_color),
    .in_row       (in_row),
    .out_valid    (out_valid),
    .out_spi_byte (out_spi_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_checked(bytes_checked)
  );

  function automatic logic [6:0] pick_row();
    if ($urandom_range(1, 0) == 1) return 7'($urandom_range(7, 0));
    return 7'($urandom_range(127, 0));
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [6:0] x, input logic [6:0] y,
                           input logic c, input logic [6:0] r);
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_pixel_x <= x;
    in_pixel_y <= y;
    in_color   <= c;
    in_row     <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd != CMD_SPARE) n_sent++;
    if (cmd == CMD_LINE || cmd == CMD_FLINE) n_refresh++;
    if (cmd == CMD_PIXEL) n_pixel++;
    if (cmd == CMD_FILL) n_fill++;
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [6:0] r);
    send_item(cmd, 7'($urandom), 7'($urandom), 1'($urandom), r);
  endtask

  task automatic hold_off();
    int n;
    n = 0;
    if (!quiet) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: n = 0;
        6, 7, 8: n = $urandom_range(3, 1);
        default: n = $urandom_range(40, 10);
      endcase
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("memory_lcd_frame_serializer_top: mismatch");
    $finish;
  end

  initial begin
    int kind;
    int lines;
    int waited;
    start      <= 1'b0;
    rst_n      <= 1'b0;
    in_cmd     <= CMD_PIXEL;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    in_color   <= 1'b0;
    in_row     <= '0;
    n_sent       = 0;
    n_refresh    = 0;
    n_pixel      = 0;
    n_fill       = 0;
    drained_once = 0;
    quiet        = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_PIXEL, 7'd0, 7'd0, 1'b0, 7'($urandom));
    send_item(CMD_PIXEL, 7'd127, 7'd0, 1'b0, 7'($urandom));
    send_item(CMD_PIXEL, 7'd64, 7'd127, 1'b0, 7'($urandom));
    send_item(CMD_PIXEL, 7'd127, 7'd127, 1'b0, 7'($urandom));
    send_item(CMD_PIXEL, 7'd9, 7'd127, 1'b0, 7'($urandom));
    send_cmd(CMD_LINE, 7'd0);
    send_cmd(CMD_LINE, 7'd127);
    send_item(CMD_PIXEL, 7'd0, 7'd0, 1'b1, 7'($urandom));
    send_cmd(CMD_FBEGIN, 7'($urandom));
    send_cmd(CMD_FLINE, 7'd0);
    send_cmd(CMD_FLINE, 7'd127);
    send_cmd(CMD_FEND, 7'($urandom));
    send_cmd(CMD_CLEAR, 7'($urandom));
    send_cmd(CMD_SPARE, 7'($urandom));
    send_cmd(CMD_FILL, 7'($urandom));
    send_cmd(CMD_LINE, 7'd127);
    send_cmd(CMD_FEND, 7'($urandom));
    send_cmd(CMD_FLINE, 7'd64);
    send_cmd(CMD_FBEGIN, 7'($urandom));
    drain_results();

    while (n_sent < 410) begin
      quiet = ((n_sent / 30) % 4 == 3);
      kind  = $urandom_range(99, 0);
      if (kind < 40) begin
        send_item(CMD_PIXEL, 7'($urandom), pick_row(), 1'($urandom), 7'($urandom));
      end else if (kind < 55) begin
        send_cmd(CMD_LINE, pick_row());
      end else if (kind < 75) begin
        send_cmd(CMD_FBEGIN, 7'($urandom));
        hold_off();
        lines = $urandom_range(4, 1);
        repeat (lines) begin
          send_cmd(CMD_FLINE, pick_row());
          hold_off();
        end
        send_cmd(CMD_FEND, 7'($urandom));
      end else if (kind < 82) begin
        send_cmd(CMD_CLEAR, 7'($urandom));
      end else if (kind < 84 && n_fill < 6) begin
        send_cmd(CMD_FILL, 7'($urandom));
      end else if (kind < 90) begin
        send_cmd(3'($urandom_range(CMD_FEND, CMD_FBEGIN)), pick_row());
      end else if (kind < 95) begin
        send_cmd(CMD_SPARE, 7'($urandom));
      end else begin
        send_item(3'($urandom_range(CMD_FEND, CMD_PIXEL)), 7'($urandom), 7'($urandom),
                  1'($urandom), 7'($urandom));
      end
      if (drained_once == 0 && n_sent >= 220) begin
        drained_once = 1;
        drain_results();
      end else begin
        hold_off();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);

    $display("covered %0d commands: %0d pixel writes, %0d line sends, %0d fills",
             n_sent, n_pixel, n_refresh, n_fill);
    $display("compared %0d SPI bytes, %0d still outstanding", bytes_checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("memory_lcd_frame_serializer_top: match");
    end else begin
      $display("memory_lcd_frame_serializer_top: mismatch");
    end
    $finish;
  end

endmodule
